[design/vtpd_pkg.sv]
`timescale 1ns / 1ps
package vtpd_pkg;
   localparam int DefFracBits = 16;
   localparam int WordBits    = 32;
   localparam int RegBits     = 64;
   localparam int NumRegs     = 8;
   localparam int IdxBits     = 3;
   localparam int SumBits     = 58;
   localparam int ProdBits    = 64;
endpackage

[design/vertex_transform_persp_divide.sv]
`timescale 1ns / 1ps
// Streaming 4x4 homogeneous vertex transform with perspective divide, signed
// fixed point with FRAC_BITS fraction bits. One transaction per cycle
// sustained while the output is not stalled. A transaction accepted at one
// edge passes the input, product, column sum and sign stages (4), the
// divider's entry stage and 33 quotient-bit stages (34), then the output
// register, before it is presented on the rsp_ side. Most of the depth comes
// from the bit-per-stage divider. The whole pipeline advances together; it
// holds, with req_stall set, whenever the output register holds a transaction
// and rsp_stall is set. A zero w gives zero coordinates and w_is_zero set.
module vertex_transform_persp_divide #(
   parameter int FRAC_BITS = vtpd_pkg::DefFracBits
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [vtpd_pkg::WordBits-1:0] req_in_x,
   input  logic signed [vtpd_pkg::WordBits-1:0] req_in_y,
   input  logic signed [vtpd_pkg::WordBits-1:0] req_in_z,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [vtpd_pkg::WordBits-1:0] rsp_out_x,
   output logic signed [vtpd_pkg::WordBits-1:0] rsp_out_y,
   output logic signed [vtpd_pkg::WordBits-1:0] rsp_out_z,
   output logic rsp_w_is_zero,
   input  logic csr_write,
   input  logic [vtpd_pkg::IdxBits-1:0] csr_index,
   input  logic [vtpd_pkg::RegBits-1:0] csr_data
);
   import vtpd_pkg::*;
   localparam int DivLat = 34;
   localparam int Lat    = 4 + DivLat; // stages before output register

   logic [RegBits-1:0] mat_ff [NumRegs];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumRegs; i++) mat_ff[i] <= '0;
         mat_ff[0] <= RegBits'(1);
      end else if (csr_write) begin
         mat_ff[csr_index] <= csr_data;
      end
   end

   function automatic logic signed [WordBits-1:0] elem(input int r, input int c);
      logic [RegBits-1:0] rg;
      rg = mat_ff[IdxBits'(2 * r + (c >> 1))];
      return c[0] ? rg[RegBits-1:WordBits] : rg[WordBits-1:0];
   endfunction

   // global advance: pipe moves when output register can take data
   logic adv;
   logic [Lat-1:0] v_ff;
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (adv) v_ff <= {v_ff[Lat-2:0], req_valid};
   end

   // stage 1: register inputs
   logic signed [WordBits-1:0] in_ff [3];
   always_ff @(posedge clock)
      if (adv) begin
         in_ff[0] <= req_in_x; in_ff[1] <= req_in_y; in_ff[2] <= req_in_z;
      end

   // stage 2: twelve products, floor-shifted
   logic signed [ProdBits-1:0] pr_ff [3][4];
   for (genvar r = 0; r < 3; r++) begin : g_r
      for (genvar c = 0; c < 4; c++) begin : g_c
         logic signed [ProdBits-1:0] p;
         assign p = ProdBits'(in_ff[r]) * ProdBits'(elem(r, c));
         always_ff @(posedge clock)
            if (adv) pr_ff[r][c] <= p >>> FRAC_BITS;
      end
   end

   // stage 3: column sums
   logic signed [SumBits-1:0] sum_ff [4];
   for (genvar c = 0; c < 4; c++) begin : g_s
      always_ff @(posedge clock)
         if (adv) sum_ff[c] <= SumBits'(pr_ff[0][c]) + SumBits'(pr_ff[1][c])
                             + SumBits'(pr_ff[2][c]) + SumBits'(elem(3, c));
   end

   // stage 4: magnitudes and signs
   logic [SumBits-1:0] nm_ff [3];
   logic               ng_ff [3];
   logic [SumBits-1:0] dm_ff;
   logic               wz_ff [DivLat+1];
   always_ff @(posedge clock)
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            nm_ff[c] <= sum_ff[c][SumBits-1] ? SumBits'(-sum_ff[c]) : sum_ff[c];
            ng_ff[c] <= sum_ff[c][SumBits-1] ^ sum_ff[3][SumBits-1];
         end
         dm_ff    <= sum_ff[3][SumBits-1] ? SumBits'(-sum_ff[3]) : sum_ff[3];
         wz_ff[0] <= sum_ff[3] == '0;
         for (int k = 0; k < DivLat; k++) wz_ff[k+1] <= wz_ff[k];
      end

   logic signed [WordBits-1:0] q [3];
   for (genvar c = 0; c < 3; c++) begin : g_d
      vtpd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
         .clock(clock), .adv(adv), .num_mag(nm_ff[c]),
         .den_mag(dm_ff | SumBits'(wz_ff[0])), .neg(ng_ff[c]), .quo(q[c])
      );
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (adv) rsp_valid <= v_ff[Lat-1];
   end
   always_ff @(posedge clock)
      if (adv) begin
         rsp_out_x     <= wz_ff[DivLat] ? '0 : q[0];
         rsp_out_y     <= wz_ff[DivLat] ? '0 : q[1];
         rsp_out_z     <= wz_ff[DivLat] ? '0 : q[2];
         rsp_w_is_zero <= wz_ff[DivLat];
      end
endmodule

[design/vtpd_div.sv]
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage
// magnitude of (n << FRAC_BITS) / d, saturated at limit, sign applied at the end
module vtpd_div #(
   parameter int FRAC_BITS = vtpd_pkg::DefFracBits
) (
   input  logic clock,
   input  logic adv,
   input  logic [vtpd_pkg::SumBits-1:0] num_mag,
   input  logic [vtpd_pkg::SumBits-1:0] den_mag,
   input  logic neg,
   output logic signed [vtpd_pkg::WordBits-1:0] quo
);
   import vtpd_pkg::*;
   localparam int NB = SumBits + FRAC_BITS;  // dividend bits
   localparam int QB = 33;                   // quotient bits kept before saturation
   // quotient >= 2^QB means saturate; check high dividend part against divisor first
   localparam int NS = QB;

   // stage arrays
   logic [NB-1:0]      n_ff [NS+1];
   logic [SumBits-1:0] d_ff [NS+1];
   logic [SumBits:0]   r_ff [NS+1];
   logic [QB-1:0]      q_ff [NS+1];
   logic               s_ff [NS+1];
   logic               ov_ff[NS+1];

   logic [NB-1:0] num_ext;
   assign num_ext = {num_mag, {FRAC_BITS{1'b0}}};

   // entry: overflow iff top (NB-QB) bits >= d
   always_ff @(posedge clock) begin
      if (adv) begin
         n_ff[0]  <= num_ext;
         d_ff[0]  <= den_mag;
         r_ff[0]  <= (SumBits+1)'(num_ext[NB-1:QB]);
         q_ff[0]  <= '0;
         s_ff[0]  <= neg;
         ov_ff[0] <= (SumBits+1)'(num_ext[NB-1:QB]) >= {1'b0, den_mag};
      end
   end

   for (genvar k = 0; k < NS; k++) begin : g_st
      logic [SumBits+1:0] t;
      logic               ge;
      assign t  = {r_ff[k], n_ff[k][QB-1-k]};
      assign ge = t >= {2'b0, d_ff[k]};
      always_ff @(posedge clock) begin
         if (adv) begin
            n_ff[k+1]  <= n_ff[k];
            d_ff[k+1]  <= d_ff[k];
            r_ff[k+1]  <= ge ? (SumBits+1)'(t - {2'b0, d_ff[k]}) : (SumBits+1)'(t);
            q_ff[k+1]  <= {q_ff[k][QB-2:0], ge};
            s_ff[k+1]  <= s_ff[k];
            ov_ff[k+1] <= ov_ff[k];
         end
      end
   end

   logic [QB-1:0] lim;
   logic [QB-1:0] mag;
   always_comb begin
      lim = s_ff[NS] ? QB'(33'h080000000) : QB'(33'h07fffffff);
      mag = (ov_ff[NS] || q_ff[NS] > lim) ? lim : q_ff[NS];
      quo = s_ff[NS] ? WordBits'(-mag) : WordBits'(mag);
   end
endmodule

[tb/sv/tb_vertex_transform_persp_divide.sv]
`timescale 1ns / 1ps
module tb_vertex_transform_persp_divide;
   import vtpd_pkg::*;

   localparam int FracBits   = DefFracBits;
   localparam int Latency    = 40;
   localparam int CycleLimit = 600000;
   localparam int RandItems  = 2000;
   localparam int NumPhases  = 9;
   localparam logic [WordBits-1:0] One = 32'h0001_0000;

   typedef struct {
      logic signed [WordBits-1:0] x;
      logic signed [WordBits-1:0] y;
      logic signed [WordBits-1:0] z;
   } vertex_type;

   typedef struct {
      logic signed [WordBits-1:0] x;
      logic signed [WordBits-1:0] y;
      logic signed [WordBits-1:0] z;
      logic                       wz;
   } projected_type;

   // matrix kinds for reprogramming
   typedef enum int {
      MatPersp, MatRandom, MatOnes, MatMinHalves, MatMaxHalves
   } mat_kind_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [WordBits-1:0] req_in_x;
   logic signed [WordBits-1:0] req_in_y;
   logic signed [WordBits-1:0] req_in_z;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [WordBits-1:0] rsp_out_x;
   logic signed [WordBits-1:0] rsp_out_y;
   logic signed [WordBits-1:0] rsp_out_z;
   logic rsp_w_is_zero;
   logic csr_write;
   logic [IdxBits-1:0] csr_index;
   logic [RegBits-1:0] csr_data;

   vertex_transform_persp_divide #(.FRAC_BITS(FracBits)) dut (.*);

   // shadow copy of the matrix registers
   logic [RegBits-1:0] mat_shadow [NumRegs];

   vertex_type    vertex_q [$];    // vertices waiting to be offered
   projected_type projected_q [$]; // predicted results in order
   int  errors;
   int  cycles;
   int  snd_idle;
   int  rcv_idle;
   bit  req_taken;
   bit  start_hold;
   int  hold_cnt;

   // clock and cycle limit
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // signed matrix element m[r][c] from the packed register pairs
   function automatic longint mat_elem(int r, int c);
      logic [RegBits-1:0] word;
      word = mat_shadow[r * 2 + c / 2];
      return (c % 2) ? longint'($signed(word[63:32])) : longint'($signed(word[31:0]));
   endfunction

   // row vector (x, y, z, 1) times matrix, then divide by w with saturation
   function automatic projected_type project_vertex(vertex_type v);
      projected_type res;
      longint pt [3];
      longint col [4];
      logic signed [127:0] num;
      logic signed [127:0] den;
      logic signed [127:0] quo;
      logic signed [WordBits-1:0] q32 [3];
      pt[0] = v.x;
      pt[1] = v.y;
      pt[2] = v.z;
      for (int c = 0; c < 4; c++) begin
         col[c] = mat_elem(3, c);
         for (int r = 0; r < 3; r++) begin
            col[c] += (pt[r] * mat_elem(r, c)) >>> FracBits;
         end
      end
      if (col[3] == 0) begin
         res.x = '0;
         res.y = '0;
         res.z = '0;
         res.wz = 1'b1;
         return res;
      end
      den = col[3];
      for (int c = 0; c < 3; c++) begin
         num = col[c];
         num = num <<< FracBits;
         quo = num / den; // truncates toward zero
         if (quo > 128'sd2147483647) begin
            q32[c] = 32'h7FFF_FFFF;
         end else if (quo < -128'sd2147483648) begin
            q32[c] = 32'h8000_0000;
         end else begin
            q32[c] = quo[31:0];
         end
      end
      res.x = q32[0];
      res.y = q32[1];
      res.z = q32[2];
      res.wz = 1'b0;
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   // input side: push prediction on each accepted transaction
   // output side: compare each accepted transaction against oldest prediction
   always @(posedge clock) begin
      projected_type want;
      req_taken = 1'b0;
      if (!reset && req_valid && !req_stall) begin
         projected_q.push_back(project_vertex(vertex_q.pop_front()));
         req_taken = 1'b1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (projected_q.size() == 0) begin
            report_mismatch("unexpected transaction", 0, 0);
         end else begin
            want = projected_q.pop_front();
            if (rsp_out_x !== want.x) report_mismatch("out_x", rsp_out_x, want.x);
            if (rsp_out_y !== want.y) report_mismatch("out_y", rsp_out_y, want.y);
            if (rsp_out_z !== want.z) report_mismatch("out_z", rsp_out_z, want.z);
            if (rsp_w_is_zero !== want.wz)
               report_mismatch("w_is_zero", rsp_w_is_zero, want.wz);
         end
      end
   end

   // driver: a held transaction stays until accepted
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (vertex_q.size() > 0 && $urandom_range(0, 99) >= snd_idle) begin
            req_in_x <= vertex_q[0].x;
            req_in_y <= vertex_q[0].y;
            req_in_z <= vertex_q[0].z;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall, with one long hold-off to back the pipe up
   always @(negedge clock) begin
      if (start_hold) begin
         hold_cnt = 400;
         start_hold = 1'b0;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rcv_idle);
      end
   end

   task automatic write_reg(int idx, logic [RegBits-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx[IdxBits-1:0];
      csr_data <= value;
      mat_shadow[idx] = value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic logic [WordBits-1:0] small_word();
      return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
   endfunction

   task automatic load_matrix(mat_kind_type kind);
      logic [WordBits-1:0] e [16];
      for (int i = 0; i < 16; i++) begin
         case (kind)
            MatPersp: begin
               // near-identity with w taken from z, perturbed
               e[i] = ($urandom_range(0, 3) == 0) ? small_word() : '0;
               if (i == 0 || i == 5 || i == 10 || i == 11) e[i] = One + small_word();
               if (i >= 12) e[i] = small_word();
            end
            MatRandom:    e[i] = $urandom();
            MatOnes:      e[i] = 32'hFFFF_FFFF;
            MatMinHalves: e[i] = 32'h8000_0000;
            default:      e[i] = 32'h7FFF_FFFF;
         endcase
      end
      for (int r = 0; r < NumRegs; r++) begin
         write_reg(r, {e[r * 2 + 1], e[r * 2]});
      end
   endtask

   function automatic logic [WordBits-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         3: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
         default: return small_word();
      endcase
   endfunction

   task automatic add_vertex(logic [WordBits-1:0] x, logic [WordBits-1:0] y,
                             logic [WordBits-1:0] z);
      vertex_type v;
      v.x = x;
      v.y = y;
      v.z = z;
      vertex_q.push_back(v);
   endtask

   // idle only once the pipe has emptied, plus its latency
   task automatic wait_drained();
      while (vertex_q.size() > 0 || projected_q.size() > 0 || req_valid) @(posedge clock);
      repeat (Latency + 10) @(posedge clock);
   endtask

   initial begin
      logic [WordBits-1:0] z;
      mat_kind_type kind;
      errors = 0;
      cycles = 0;
      snd_idle = 19;
      rcv_idle = 77;
      start_hold = 1'b0;
      hold_cnt = 0;
      req_taken = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_x = '0;
      req_in_y = '0;
      req_in_z = '0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      for (int i = 0; i < NumRegs; i++) mat_shadow[i] = '0;
      mat_shadow[0] = 64'd1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset matrix has a zero w column
      add_vertex(One, One, One);
      add_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      wait_drained();

      // perspective matrix: w follows z exactly
      for (int i = 0; i < NumRegs; i++) write_reg(i, '0);
      write_reg(0, {32'h0, One});
      write_reg(2, {One, 32'h0});
      write_reg(5, {One, One});
      add_vertex(One, 32'h0002_0000, 32'h0002_0000);
      add_vertex(One, One, 32'h0);                    // zero w
      add_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h1); // overflow both ways
      add_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      add_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      add_vertex(32'hFFFF_0000, 32'h0000_8000, 32'hFFFE_0000);
      add_vertex(32'h0, 32'h0, 32'h0001_0000);
      wait_drained();

      // extreme register contents
      load_matrix(MatMaxHalves);
      add_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
      add_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      add_vertex(32'h0, 32'h0, 32'h0);
      wait_drained();
      load_matrix(MatMinHalves);
      add_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_vertex(32'h8000_0000, 32'h1, 32'hFFFF_FFFF);
      add_vertex(32'h0, 32'h0, 32'h0);
      wait_drained();

      // random phases: three idling patterns, mostly well-formed matrices
      for (int ph = 0; ph < NumPhases; ph++) begin
         if (ph < 3) begin
            snd_idle = 19;
            rcv_idle = 77;
         end else if (ph < 6) begin
            snd_idle = 77;
            rcv_idle = 19;
         end else begin
            snd_idle = 0;
            rcv_idle = 0;
         end
         case (ph)
            1: kind = MatOnes;
            4: kind = MatRandom;
            7: kind = MatMinHalves;
            8: kind = MatMaxHalves;
            default: kind = MatPersp;
         endcase
         load_matrix(kind);
         if (ph == 0) start_hold = 1'b1;
         for (int n = 0; n < RandItems / NumPhases; n++) begin
            // some z of zero so w can vanish under the perspective matrix
            z = ($urandom_range(0, 9) == 0) ? 32'h0 : rand_coord();
            add_vertex(rand_coord(), rand_coord(), z);
         end
         wait_drained();
      end

      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

[filelist.f]
design/vtpd_pkg.sv
design/vtpd_div.sv
design/vertex_transform_persp_divide.sv
tb/sv/tb_vertex_transform_persp_divide.sv
